// ===== design/asc_pkg.sv =====
`default_nettype none
package asc_pkg;

    localparam int CFG_COUNT = 4;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_ACTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_WAVE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEP_EXIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_SECONDS  = 2'd3;

    // stage codes as seen on the result
    localparam logic [2:0] STG_CODE_AWAKE   = 3'd0;
    localparam logic [2:0] STG_CODE_PREPARE = 3'd1;
    localparam logic [2:0] STG_CODE_LIGHT   = 3'd2;
    localparam logic [2:0] STG_CODE_DEEP    = 3'd3;
    localparam logic [2:0] STG_CODE_OFF     = 3'd4;

    localparam logic KIND_LIGHT = 1'b0;
    localparam logic KIND_DEEP  = 1'b1;

    // hour band thresholds
    localparam logic [4:0] HOUR_MORNING = 5'd8;
    localparam logic [4:0] HOUR_NOON    = 5'd12;
    localparam logic [4:0] HOUR_AFTER   = 5'd14;
    localparam logic [4:0] HOUR_EVENING = 5'd20;
    localparam logic [4:0] HOUR_LATE    = 5'd23;

    localparam logic [3:0] PREP_WAVE_DAY     = 4'd10;
    localparam logic [3:0] PREP_WAVE_EVENING = 4'd9;
    localparam logic [3:0] PREP_WAVE_LATE    = 4'd12;
    localparam logic [4:0] PREP_MIN_RESET    = 5'd20;
    localparam logic [4:0] PREP_MIN_EVENING  = 5'd25;
    localparam logic [4:0] PREP_MIN_LATE     = 5'd15;

    localparam logic [15:0] AWAKE_WAVE_MAX  = 16'd8;
    localparam logic [7:0]  LIGHT_TO_DEEP   = 8'd7;
    localparam logic [7:0]  BUSY_TO_AWAKE   = 8'd3;
    localparam logic [15:0] SHORT_SEGMENT   = 16'd5;
    localparam logic [8:0]  DEEP_MARGIN     = 9'd5;
    localparam logic [7:0]  OFF_SHORT_RUN   = 8'd30;
    localparam logic [7:0]  OFF_LONG_RUN    = 8'd45;

    typedef enum logic [4:0] {
        ST_AWAKE   = 5'b00001,
        ST_PREPARE = 5'b00010,
        ST_LIGHT   = 5'b00100,
        ST_DEEP    = 5'b01000,
        ST_OFF     = 5'b10000
    } t_stage;

    typedef struct packed {
        logic [15:0] action_count;
        logic [15:0] wave_count;
        logic [4:0]  hour_of_day;
        logic [31:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic [2:0]  stage;
        logic        sleep_active;
        logic        segment_valid;
        logic        segment_kind;
        logic [15:0] segment_minutes;
        logic [31:0] segment_start;
        logic [31:0] segment_end;
    } t_out;

    typedef struct packed {
        logic [15:0] quiet_action_limit;
        logic [15:0] wake_wave_limit;
        logic [15:0] deep_exit_wave;
        logic [15:0] gap_seconds;
    } t_cfg;

    typedef struct packed {
        t_stage      stage;
        logic        active;
        logic        night;
        logic [3:0]  prep_wave_lim;
        logic [4:0]  prep_min_lim;
        logic [7:0]  prep_minutes;
        logic [7:0]  quiet_run;
        logic [7:0]  busy_run;
        logic [7:0]  offwrist_run;
        logic        start_latched;
        logic [15:0] seg_count;
        logic [31:0] seg_start;
        logic [31:0] last_end;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        quiet_action_limit: 16'd15,
        wake_wave_limit:    16'd20,
        deep_exit_wave:     16'd4,
        gap_seconds:        16'd180
    };

    localparam t_state STATE_RESET = '{
        stage:         ST_AWAKE,
        active:        1'b0,
        night:         1'b0,
        prep_wave_lim: PREP_WAVE_DAY,
        prep_min_lim:  PREP_MIN_RESET,
        prep_minutes:  8'd0,
        quiet_run:     8'd0,
        busy_run:      8'd0,
        offwrist_run:  8'd0,
        start_latched: 1'b0,
        seg_count:     16'd0,
        seg_start:     32'd0,
        last_end:      32'd0
    };

    function automatic logic [7:0] inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [2:0] stage_code(input t_stage s);
        logic [2:0] c;
        case (s)
            ST_AWAKE:   c = STG_CODE_AWAKE;
            ST_PREPARE: c = STG_CODE_PREPARE;
            ST_LIGHT:   c = STG_CODE_LIGHT;
            ST_DEEP:    c = STG_CODE_DEEP;
            ST_OFF:     c = STG_CODE_OFF;
            default:    c = STG_CODE_AWAKE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/asc_cfg.sv =====
`default_nettype none
module asc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [asc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_wdata,
    output asc_pkg::t_cfg                      o_cfg
);
    import asc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUIET_ACTION: n_cfg.quiet_action_limit = i_cfg_wdata;
                CFG_WAKE_WAVE:    n_cfg.wake_wave_limit    = i_cfg_wdata;
                CFG_DEEP_EXIT:    n_cfg.deep_exit_wave     = i_cfg_wdata;
                CFG_GAP_SECONDS:  n_cfg.gap_seconds        = i_cfg_wdata;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== design/asc_step.sv =====
`default_nettype none
module asc_step (
    input  wire asc_pkg::t_cfg   i_cfg,
    input  wire asc_pkg::t_state i_state,
    input  wire asc_pkg::t_in    i_item,
    output asc_pkg::t_state      o_state,
    output asc_pkg::t_out        o_result
);
    import asc_pkg::*;

    t_state      s;
    logic        e_valid;
    logic        e_kind;
    logic [15:0] e_minutes;
    logic [31:0] e_start;
    logic [31:0] e_end;
    logic [15:0] act;
    logic [15:0] wav;
    logic [4:0]  hr;
    logic [31:0] now;
    logic        quiet;
    logic [31:0] gap;

    always_comb begin
        s         = i_state;
        e_valid   = 1'b0;
        e_kind    = KIND_LIGHT;
        e_minutes = 16'd0;
        e_start   = 32'd0;
        e_end     = 32'd0;
        gap       = 32'd0;
        act       = i_item.action_count;
        wav       = i_item.wave_count;
        hr        = i_item.hour_of_day;
        now       = i_item.now_seconds;
        quiet     = (wav == 16'd0) || (act <= i_cfg.quiet_action_limit);

        // hour band
        if (hr >= HOUR_MORNING && hr < HOUR_NOON) begin
            s.night = 1'b0;
            if (s.stage == ST_PREPARE) s.stage = ST_AWAKE;
        end else if (hr >= HOUR_NOON && hr < HOUR_AFTER) begin
            s.night = 1'b0;
            s.prep_wave_lim = PREP_WAVE_DAY;
        end else if (hr >= HOUR_AFTER && hr < HOUR_EVENING) begin
            s.night = 1'b0;
            if (s.stage == ST_PREPARE) s.stage = ST_AWAKE;
        end else if (hr >= HOUR_EVENING && hr < HOUR_LATE) begin
            s.night = 1'b1;
            s.prep_wave_lim = PREP_WAVE_EVENING;
            s.prep_min_lim  = PREP_MIN_EVENING;
        end else begin
            s.night = 1'b1;
            s.prep_wave_lim = PREP_WAVE_LATE;
            s.prep_min_lim  = PREP_MIN_LATE;
        end

        if (s.night || s.active) begin
            case (s.stage)
                ST_AWAKE: begin
                    if (wav < AWAKE_WAVE_MAX) begin
                        s.seg_start    = now;
                        s.seg_count    = 16'd0;
                        s.stage        = ST_PREPARE;
                        s.prep_minutes = 8'd0;
                        s.quiet_run    = 8'd0;
                        s.busy_run     = 8'd0;
                    end
                end
                ST_PREPARE: begin
                    if (wav > {12'd0, s.prep_wave_lim}) begin
                        s.prep_minutes = 8'd0;
                        s.active       = 1'b0;
                        s.stage        = ST_AWAKE;
                    end else begin
                        s.quiet_run    = quiet ? inc8(s.quiet_run) : 8'd0;
                        s.prep_minutes = inc8(s.prep_minutes);
                        if (s.prep_minutes > {3'd0, s.prep_min_lim}) begin
                            s.stage = ({1'b0, s.quiet_run} + DEEP_MARGIN >=
                                       {4'd0, s.prep_min_lim}) ? ST_DEEP : ST_LIGHT;
                            s.seg_count     = {8'd0, s.prep_minutes} + 16'd1;
                            s.start_latched = 1'b1;
                            s.active        = 1'b1;
                            s.prep_minutes  = 8'd0;
                            s.quiet_run     = 8'd0;
                            s.busy_run      = 8'd0;
                        end
                    end
                end
                ST_LIGHT: begin
                    if (!s.start_latched) begin
                        s.start_latched = 1'b1;
                        s.seg_start     = now;
                    end
                    s.seg_count = inc16(s.seg_count);
                    if (act == 16'd0) begin
                        s.quiet_run = inc8(s.quiet_run);
                        if (s.quiet_run >= LIGHT_TO_DEEP) begin
                            s.busy_run  = 8'd0;
                            s.quiet_run = 8'd0;
                            s.stage     = ST_DEEP;
                            if (s.seg_count > SHORT_SEGMENT) begin
                                e_valid   = 1'b1;
                                e_kind    = KIND_LIGHT;
                                e_minutes = s.seg_count;
                                e_start   = s.seg_start;
                                e_end     = now;
                                s.last_end      = now;
                                s.seg_count     = 16'd0;
                                s.start_latched = 1'b0;
                            end
                        end
                    end else begin
                        s.quiet_run = 8'd0;
                    end
                    if (wav > i_cfg.wake_wave_limit) begin
                        s.busy_run = inc8(s.busy_run);
                        if (s.busy_run >= BUSY_TO_AWAKE) begin
                            if (s.seg_count >= SHORT_SEGMENT) begin
                                e_valid   = 1'b1;
                                e_kind    = KIND_LIGHT;
                                e_minutes = s.seg_count;
                                e_start   = s.seg_start;
                                e_end     = now;
                                s.last_end = now;
                            end
                            s.seg_count     = 16'd0;
                            s.start_latched = 1'b0;
                            s.active        = 1'b0;
                            s.stage         = ST_AWAKE;
                        end
                    end else begin
                        s.busy_run = 8'd0;
                    end
                end
                ST_DEEP: begin
                    if (!s.start_latched) begin
                        s.start_latched = 1'b1;
                        s.seg_start     = now;
                    end
                    s.seg_count = inc16(s.seg_count);
                    if (wav >= i_cfg.deep_exit_wave) begin
                        s.stage     = ST_LIGHT;
                        s.quiet_run = 8'd0;
                        s.busy_run  = 8'd0;
                        if (s.seg_count > SHORT_SEGMENT) begin
                            e_valid   = 1'b1;
                            e_kind    = KIND_DEEP;
                            e_minutes = s.seg_count;
                            e_start   = s.seg_start;
                            e_end     = now;
                            s.last_end      = now;
                            s.seg_count     = 16'd0;
                            s.start_latched = 1'b0;
                        end
                    end
                end
                ST_OFF: begin
                    if (wav != 16'd0) begin
                        s.stage  = ST_AWAKE;
                        s.active = 1'b0;
                    end
                end
                default: s = i_state;
            endcase

            // taken-off detector
            if (s.stage != ST_OFF) begin
                if (quiet) begin
                    s.offwrist_run = inc8(s.offwrist_run);
                    gap = s.seg_start - s.last_end;
                    if ((s.offwrist_run >= OFF_SHORT_RUN &&
                         gap >= {16'd0, i_cfg.gap_seconds}) ||
                        s.offwrist_run >= OFF_LONG_RUN) begin
                        s.offwrist_run = 8'd0;
                        s.active       = 1'b0;
                        s.stage        = ST_OFF;
                    end
                end else begin
                    s.offwrist_run = 8'd0;
                end
            end
        end
    end

    assign o_state = s;

    always_comb begin
        o_result.stage           = stage_code(s.stage);
        o_result.sleep_active    = s.active;
        o_result.segment_valid   = e_valid;
        o_result.segment_kind    = e_kind;
        o_result.segment_minutes = e_minutes;
        o_result.segment_start   = e_start;
        o_result.segment_end     = e_end;
    end

endmodule
`default_nettype wire

// ===== design/activity_sleep_stage_classifier_top.sv =====
// Sleep stage classifier, one input item per minute of motion activity.
// Input channel: i_in_valid / o_in_ready with i_in_data (action count, wave
// count, hour, seconds stamp). Output channel: o_out_valid / i_out_ready with
// o_out_data (stage, sleep flag and, when a light or deep segment closes,
// its kind, minutes, start and end stamps). Every item gives one result.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 quiet action limit, 1 wake wave limit, 2 deep exit wave, 3 gap seconds)
// at the clock edge; write only while no item is in flight.
// An item is held in the input register, goes through the stage update
// and lands in the result register. Throughput: one item per cycle while
// the receiver takes results, set by the single combinational stage update.
// A stalled receiver holds the result; one more item is taken into the input
// register, then o_in_ready drops until the result is taken.
// Reset (synchronous, active low) clears the stage state to awake, the
// configuration to its defaults, and empties both registers.
`default_nettype none
module activity_sleep_stage_classifier_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire asc_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output asc_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [asc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_wdata
);
    import asc_pkg::*;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_in    r_in;
    logic   r_in_vld;
    t_out   r_out;
    t_out   n_out;
    logic   r_out_vld;
    logic   adv;

    asc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    asc_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // the held item moves on when the result register is free or being drained
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // light and deep are only ever reached with detection engaged
    a_deep_light_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stage == ST_LIGHT || r_state.stage == ST_DEEP) |-> r_state.active)
        else $error("light or deep stage without sleep_active");

    // a closed deep segment always drops to light or taken off
    a_deep_close_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.segment_valid && r_out.segment_kind == KIND_DEEP) |->
        (r_out.stage == STG_CODE_LIGHT || r_out.stage == STG_CODE_OFF))
        else $error("deep segment closed into an unexpected stage");

    // segment fields stay clear when no segment closed
    a_no_segment_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.segment_valid) |->
        (r_out.segment_minutes == 16'd0 && r_out.segment_start == 32'd0 &&
         r_out.segment_end == 32'd0))
        else $error("segment fields set without a closed segment");

    // a held input item is not overwritten while it waits
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_in)))
        else $error("waiting input item lost or changed");

endmodule
`default_nettype wire
